// ----- sv/xxf_pkg.sv -----
package xxf_pkg;

    localparam int unsigned DEPTH_DEF = 8;

    localparam logic [7:0] CHAR_SOH = 8'h01;
    localparam logic [7:0] CHAR_ETX = 8'h03;

    localparam logic [3:0] UPPER_RST = 4'd6;
    localparam logic [2:0] LOWER_RST = 3'd2;
    localparam logic [7:0] XON_RST   = 8'd17;
    localparam logic [7:0] XOFF_RST  = 8'd19;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER = 2'd0,
        CFG_LOWER = 2'd1,
        CFG_XON   = 2'd2,
        CFG_XOFF  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_RX  = 1'b0,
        REQ_GET = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_byte;
        logic       flow_send;
        logic [7:0] flow_char;
        logic       dropped;
        logic       end_seen;
        logic [3:0] fill_count;
    } t_res;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;
        logic emit;
    } t_ctl;

endpackage

// ----- sv/xxf_ram.sv -----
module xxf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/xxf_ctrl.sv -----
module xxf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output xxf_pkg::t_ctl o_ctl
);
    import xxf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_busy       = 1'b0;
        o_ctl.accept = 1'b0;
        o_ctl.emit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.accept = 1'b1;
                    n_state      = ST_RESP;
                end
            end
            ST_RESP: begin
                // ring read data lands this cycle
                o_busy     = 1'b1;
                o_ctl.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/xxf_dp.sv -----
module xxf_dp #(
    parameter int unsigned DEPTH = xxf_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xxf_pkg::t_ctl              i_ctl,
    input  xxf_pkg::t_req              i_req,
    input  logic                       i_cfg_valid,
    input  logic [xxf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output xxf_pkg::t_res              o_res,
    output logic                       o_done
);
    import xxf_pkg::*;

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > 4) ? CW : 4;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_flow_on, n_flow_on;
    logic          r_esc, n_esc;

    logic [3:0]    r_upper;
    logic [2:0]    r_lower;
    logic [7:0]    r_xon;
    logic [7:0]    r_xoff;

    t_res          r_res, n_res;

    logic          is_get;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        res = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
        return res;
    endfunction

    assign is_get = (i_req.req_type == REQ_GET);
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign wr_en  = i_ctl.accept && !is_get && !full;
    assign rd_en  = i_ctl.accept && is_get && !empty;

    xxf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_req.rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_flow_on = r_flow_on;
        n_esc     = r_esc;
        n_res     = '0;
        if (!is_get) begin
            n_res.end_seen = (i_req.rx_byte == 8'd0) && !r_esc;
            n_esc = (i_req.rx_byte == CHAR_SOH) || (i_req.rx_byte == CHAR_ETX);
            if (!full) begin
                n_tail  = next_slot(r_tail);
                n_count = r_count + CW'(1);
            end else begin
                n_res.dropped = 1'b1;
            end
            if ((CMPW'(n_count) >= CMPW'(r_upper)) && r_flow_on) begin
                n_flow_on       = 1'b0;
                n_res.flow_send = 1'b1;
                n_res.flow_char = r_xoff;
            end
        end else if (!empty) begin
            n_res.pop_valid = 1'b1;
            n_head  = next_slot(r_head);
            n_count = r_count - CW'(1);
            if ((CMPW'(n_count) <= CMPW'(r_lower)) && !r_flow_on) begin
                n_flow_on       = 1'b1;
                n_res.flow_send = 1'b1;
                n_res.flow_char = r_xon;
            end
        end
        // fill count is reported modulo 16
        n_res.fill_count = 4'(CMPW'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_flow_on <= 1'b1;
            r_esc     <= 1'b0;
        end else if (i_ctl.accept) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_flow_on <= n_flow_on;
            r_esc     <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RST;
            r_lower <= LOWER_RST;
            r_xon   <= XON_RST;
            r_xoff  <= XOFF_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_UPPER: r_upper <= i_cfg_data[3:0];
                CFG_LOWER: r_lower <= i_cfg_data[2:0];
                CFG_XON:   r_xon   <= i_cfg_data;
                CFG_XOFF:  r_xoff  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb begin
        o_res          = r_res;
        o_res.pop_byte = r_res.pop_valid ? rd_data : 8'd0;
    end

    assign o_done = i_ctl.emit;

endmodule

// ----- sv/xon_xoff_receive_fifo.sv -----
// Receive byte FIFO with XON/XOFF flow control.
// Command channel: raise i_start with i_req; the item is taken on a clock
// edge where o_busy is low. req_type REQ_RX stores rx_byte (or flags a drop
// when full); REQ_GET pops the oldest byte.
// Each item yields one result on o_res, marked by o_done for a single cycle.
// The result appears in the cycle after the item is taken, since the ring
// store has a registered read port; a new item may be taken the cycle after
// that, so one item every 2 cycles. The ring read port sets that figure.
// o_res carries the popped byte, the XON/XOFF character to send (flow_send),
// the drop and end-of-transfer flags and the fill count after the item.
// The receiver cannot stall: o_done is a strobe and must be taken when seen.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 upper
// limit, 1 lower limit, 2 XON char, 3 XOFF char. Write only when idle.
// Reset (synchronous, active low) empties the buffer, turns flow on and
// restores the limits and characters to 6, 2, 17 and 19. Store contents
// are not cleared; entries are only read after being written.
module xon_xoff_receive_fifo #(
    parameter int unsigned DEPTH = xxf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  xxf_pkg::t_req                 i_req,
    output xxf_pkg::t_res                 o_res,
    output logic                          o_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [xxf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import xxf_pkg::*;

    t_ctl ctl;

    assign o_cfg_ready = 1'b1;

    xxf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_ctl   (ctl)
    );

    xxf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res),
        .o_done      (o_done)
    );

endmodule
